/* src/ilir_pkg.sv */
// Shared types and constants for the indexed list block.
// Used by the controller, the datapath and the top level; depends on nothing.
package ilir_pkg;

	localparam int POS_W   = 7;
	localparam int VALUE_W = 32;
	localparam int STS_W   = 2;

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_READ   = 3'd3,
		OP_WRITE  = 3'd4,
		OP_CLEAR  = 3'd5,
		OP_SETLEN = 3'd6
	} op_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RA_POS    = 2'd0,
		RA_CUR_DN = 2'd1,
		RA_CUR_UP = 2'd2
	} ra_sel_t;

	typedef enum logic [1:0] {
		WA_POS = 2'd0,
		WA_LEN = 2'd1,
		WA_CUR = 2'd2
	} wa_sel_t;

	typedef enum logic {
		WD_VALUE = 1'b0,
		WD_RDATA = 1'b1
	} wd_sel_t;

	typedef enum logic [2:0] {
		CUR_HOLD     = 3'd0,
		CUR_LOAD_LEN = 3'd1,
		CUR_LOAD_POS = 3'd2,
		CUR_INC      = 3'd3,
		CUR_DEC      = 3'd4
	} cur_op_t;

	typedef enum logic [2:0] {
		LEN_HOLD = 3'd0,
		LEN_INC  = 3'd1,
		LEN_DEC  = 3'd2,
		LEN_ZERO = 3'd3,
		LEN_SET  = 3'd4
	} len_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    ram_re;
		logic    ram_we;
		ra_sel_t ra_sel;
		wa_sel_t wa_sel;
		wd_sel_t wd_sel;
		cur_op_t cur_op;
		len_op_t len_op;
		logic    finish;
		logic    rd_ok;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic err;
		logic cur_at_pos;
		logic rem_more;
	} sts_t;

endpackage

/* src/ilir_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ilir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/ilir_ctrl.sv */
// Controller state machine for the indexed list: sequences each operation
// and owns both handshakes. Depends on ilir_pkg.
module ilir_ctrl
	import ilir_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_EXEC    = 5'b00010,
		S_SCAN    = 5'b00100,
		S_MOVE    = 5'b01000,
		S_RD_WAIT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// The result register may be refilled when it is empty or its beat leaves this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.ram_re = 1'b0;
		cmd.ram_we = 1'b0;
		cmd.ra_sel = RA_POS;
		cmd.wa_sel = WA_POS;
		cmd.wd_sel = WD_VALUE;
		cmd.cur_op = CUR_HOLD;
		cmd.len_op = LEN_HOLD;
		cmd.finish = 1'b0;
		cmd.rd_ok  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.err) begin
					if (out_free) begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					unique case (sts.op)
						OP_APPEND: begin
							if (out_free) begin
								cmd.ram_we = 1'b1;
								cmd.wa_sel = WA_LEN;
								cmd.len_op = LEN_INC;
								cmd.finish = 1'b1;
								state_d    = S_IDLE;
							end
						end
						OP_INSERT: begin
							cmd.cur_op = CUR_LOAD_LEN;
							state_d    = S_SCAN;
						end
						OP_REMOVE: begin
							cmd.cur_op = CUR_LOAD_POS;
							state_d    = S_SCAN;
						end
						OP_READ: begin
							cmd.ram_re = 1'b1;
							cmd.ra_sel = RA_POS;
							state_d    = S_RD_WAIT;
						end
						OP_WRITE: begin
							if (out_free) begin
								cmd.ram_we = 1'b1;
								cmd.wa_sel = WA_POS;
								cmd.finish = 1'b1;
								state_d    = S_IDLE;
							end
						end
						OP_CLEAR: begin
							if (out_free) begin
								cmd.len_op = LEN_ZERO;
								cmd.finish = 1'b1;
								state_d    = S_IDLE;
							end
						end
						OP_SETLEN: begin
							if (out_free) begin
								cmd.len_op = LEN_SET;
								cmd.finish = 1'b1;
								state_d    = S_IDLE;
							end
						end
						default: begin
							if (out_free) begin
								cmd.finish = 1'b1;
								state_d    = S_IDLE;
							end
						end
					endcase
				end
			end
			S_SCAN: begin
				if (sts.op == OP_INSERT) begin
					// Once the cursor reaches the index, the gap is open.
					if (sts.cur_at_pos) begin
						if (out_free) begin
							cmd.ram_we = 1'b1;
							cmd.wa_sel = WA_POS;
							cmd.len_op = LEN_INC;
							cmd.finish = 1'b1;
							state_d    = S_IDLE;
						end
					end else begin
						cmd.ram_re = 1'b1;
						cmd.ra_sel = RA_CUR_DN;
						state_d    = S_MOVE;
					end
				end else begin
					if (sts.rem_more) begin
						cmd.ram_re = 1'b1;
						cmd.ra_sel = RA_CUR_UP;
						state_d    = S_MOVE;
					end else if (out_free) begin
						cmd.len_op = LEN_DEC;
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				end
			end
			S_MOVE: begin
				cmd.ram_we = 1'b1;
				cmd.wa_sel = WA_CUR;
				cmd.wd_sel = WD_RDATA;
				cmd.cur_op = (sts.op == OP_INSERT) ? CUR_DEC : CUR_INC;
				state_d    = S_SCAN;
			end
			S_RD_WAIT: begin
				if (out_free) begin
					cmd.rd_ok  = 1'b1;
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && out_stall))
		else $error("result overwritten while the output beat was stalled");

	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished operation did not present a result");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_EXEC))
		else $error("accepted beat did not start execution");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ram_we && cmd.ram_re))
		else $error("store read and written in the same cycle");

endmodule

/* src/ilir_dpath.sv */
// Datapath for the indexed list: entry store, length, shift cursor, checks
// and result registers. Depends on ilir_pkg and ilir_ram.
module ilir_dpath
	import ilir_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic [2:0]                op,
	input  logic [POS_W-1:0]          position,
	input  logic signed [VALUE_W-1:0] item_value,
	input  logic [POS_W-1:0]          new_length,
	output logic signed [VALUE_W-1:0] read_value,
	output logic [POS_W-1:0]          length_now,
	output logic                      is_empty,
	output logic [STS_W-1:0]          status
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int LEN_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

	op_t                      op_q;
	logic [POS_W-1:0]         pos_q;
	logic [POS_W-1:0]         req_q;
	logic [VALUE_BITS-1:0]    val_q;
	logic [LEN_W-1:0]         len_q;
	logic [LEN_W-1:0]         len_next;
	logic [IDX_W-1:0]         cur_q;
	logic signed [VALUE_W-1:0] read_value_q;
	logic [POS_W-1:0]         length_now_q;
	logic                     is_empty_q;
	status_t                  status_q;

	status_t               status_code;
	logic [CMP_W-1:0]      pos_c, len_c, req_c, depth_c;
	logic                  full;
	logic [IDX_W-1:0]      raddr, waddr;
	logic [VALUE_BITS-1:0] wdata, rdata;

	assign pos_c   = CMP_W'(pos_q);
	assign len_c   = CMP_W'(len_q);
	assign req_c   = CMP_W'(req_q);
	assign depth_c = CMP_W'(DEPTH);
	assign full    = (len_q == LEN_W'(DEPTH));

	// Insert checks the index before the capacity.
	always_comb begin
		status_code = ST_OK;
		unique case (op_q) inside
			OP_APPEND: begin
				if (full) status_code = ST_FULL;
			end
			OP_INSERT: begin
				if (pos_c > len_c) status_code = ST_RANGE;
				else if (full) status_code = ST_FULL;
			end
			OP_REMOVE, OP_READ, OP_WRITE: begin
				if (pos_c >= len_c) status_code = ST_RANGE;
			end
			OP_SETLEN: begin
				if (req_c > depth_c) status_code = ST_FULL;
			end
			default: begin
				status_code = ST_OK;
			end
		endcase
	end

	assign sts.op         = op_q;
	assign sts.err        = (status_code != ST_OK);
	assign sts.cur_at_pos = (CMP_W'(cur_q) == pos_c);
	assign sts.rem_more   = ((LEN_W'(cur_q) + LEN_W'(1)) < len_q);

	always_comb begin
		case (cmd.ra_sel)
			RA_CUR_DN: raddr = cur_q - IDX_W'(1);
			RA_CUR_UP: raddr = cur_q + IDX_W'(1);
			default:   raddr = IDX_W'(pos_q);
		endcase
		case (cmd.wa_sel)
			WA_LEN:  waddr = IDX_W'(len_q);
			WA_CUR:  waddr = cur_q;
			default: waddr = IDX_W'(pos_q);
		endcase
		wdata = (cmd.wd_sel == WD_RDATA) ? rdata : val_q;
	end

	always_comb begin
		case (cmd.len_op)
			LEN_INC:  len_next = len_q + LEN_W'(1);
			LEN_DEC:  len_next = len_q - LEN_W'(1);
			LEN_ZERO: len_next = '0;
			LEN_SET:  len_next = LEN_W'(req_q);
			default:  len_next = len_q;
		endcase
	end

	ilir_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else begin
			len_q <= len_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(op);
			pos_q <= position;
			req_q <= new_length;
			val_q <= VALUE_BITS'(item_value);
		end
		case (cmd.cur_op)
			CUR_LOAD_LEN: cur_q <= IDX_W'(len_q);
			CUR_LOAD_POS: cur_q <= IDX_W'(pos_q);
			CUR_INC:      cur_q <= cur_q + IDX_W'(1);
			CUR_DEC:      cur_q <= cur_q - IDX_W'(1);
			default:      cur_q <= cur_q;
		endcase
		if (cmd.finish) begin
			read_value_q <= cmd.rd_ok ? VALUE_W'(signed'(rdata)) : '0;
			length_now_q <= POS_W'(len_next);
			is_empty_q   <= (len_next == '0);
			status_q     <= status_code;
		end
	end

	assign read_value = read_value_q;
	assign length_now = length_now_q;
	assign is_empty   = is_empty_q;
	assign status     = status_q;

	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(DEPTH))
		else $error("list length exceeded the store depth");

endmodule

/* src/indexed_list_insert_remove_top.sv */
// Top level of the indexed list with insert and remove.
// Joins ilir_ctrl and ilir_dpath; depends on ilir_pkg.
//
// Usage: one operation per input beat (op, position, item_value, new_length)
// on in_valid/in_stall; one result beat per operation (read_value,
// length_now, is_empty, status) on out_valid/out_stall. A beat moves at a
// clock edge where valid is high and stall is low.
// The block works on one operation at a time; in_stall is high from the
// cycle after a beat is taken until the operation has finished.
// A read waits on the registered read of the entry store. Insert at index p
// moves each entry from p up by one slot, last first; remove at index p moves
// each entry above p down by one slot. Each moved entry takes a read then a
// write, as the entry store's read data is registered and the write waits
// for it.
// A result waits in the output register while out_stall is high; the next
// beat may still be taken, and its work stops at its final step until the
// output register is free. Reset clears the length and both handshakes;
// the entry contents are undefined until written, and no clearing pass runs.
module indexed_list_insert_remove_top
	import ilir_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [2:0]                op,
	input  logic [POS_W-1:0]          position,
	input  logic signed [VALUE_W-1:0] item_value,
	input  logic [POS_W-1:0]          new_length,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] read_value,
	output logic [POS_W-1:0]          length_now,
	output logic                      is_empty,
	output logic [STS_W-1:0]          status
);

	cmd_t cmd;
	sts_t sts;

	ilir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ilir_dpath #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (op),
		.position   (position),
		.item_value (item_value),
		.new_length (new_length),
		.read_value (read_value),
		.length_now (length_now),
		.is_empty   (is_empty),
		.status     (status)
	);

endmodule

/* tb/sv/ilir_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the indexed list: watches both beat channels, keeps its own copy of the list,
// predicts every result and compares it field by field. Depends on ilir_pkg.
module ilir_result_checker
	import ilir_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [2:0]                op,
	input  logic [POS_W-1:0]          position,
	input  logic signed [VALUE_W-1:0] item_value,
	input  logic [POS_W-1:0]          new_length,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [VALUE_W-1:0] read_value,
	input  logic [POS_W-1:0]          length_now,
	input  logic                      is_empty,
	input  logic [STS_W-1:0]          status,
	output int                        mismatches,
	output int                        pending,
	output int                        checked
);

	localparam int PRINT_CAP = 100;

	typedef struct {
		logic [VALUE_W-1:0] read_value;
		logic [POS_W-1:0]   length_now;
		logic               is_empty;
		status_t            status;
	} list_result_t;

	logic [VALUE_W-1:0] list_store [DEPTH];
	int                 list_count;
	list_result_t       expected_results [$];
	list_result_t       next_expected;
	list_result_t       oldest;

	task automatic flag_mismatch(input string what, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t: result %0d, %s: got %h, expected %h", $time, checked, what, got,
				want);
		mismatches++;
	endtask

	// Applies one operation to the local copy of the list and works out its result.
	task automatic predict_list_op(input logic [2:0] code, input logic [POS_W-1:0] pos,
			input logic [VALUE_W-1:0] val, input logic [POS_W-1:0] req,
			output list_result_t res);
		logic [VALUE_W-1:0] kept;
		// Entries are held sign-extended from VALUE_BITS, so that a read is a plain copy.
		kept = val;
		for (int b = VALUE_BITS; b < VALUE_W; b++)
			kept[b] = val[VALUE_BITS-1];
		res.read_value = '0;
		res.status = ST_OK;
		case (code)
		OP_APPEND: begin
			if (list_count >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				list_store[list_count] = kept;
				list_count++;
			end
		end
		OP_INSERT: begin
			// The index check takes precedence over the full check.
			if (pos > list_count) begin
				res.status = ST_RANGE;
			end else if (list_count >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				for (int i = list_count; i > pos; i--)
					list_store[i] = list_store[i - 1];
				list_store[pos] = kept;
				list_count++;
			end
		end
		OP_REMOVE: begin
			if (pos >= list_count) begin
				res.status = ST_RANGE;
			end else begin
				// The vacated top slot keeps what it held.
				for (int i = pos; i + 1 < list_count; i++)
					list_store[i] = list_store[i + 1];
				list_count--;
			end
		end
		OP_READ: begin
			if (pos >= list_count)
				res.status = ST_RANGE;
			else
				res.read_value = list_store[pos];
		end
		OP_WRITE: begin
			if (pos >= list_count)
				res.status = ST_RANGE;
			else
				list_store[pos] = kept;
		end
		OP_CLEAR: begin
			list_count = 0;
		end
		OP_SETLEN: begin
			if (req > DEPTH)
				res.status = ST_FULL;
			else
				list_count = req;
		end
		default: begin
		end
		endcase
		res.length_now = POS_W'(list_count);
		res.is_empty = (list_count == 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_count = 0;
			expected_results.delete();
			mismatches = 0;
			checked = 0;
			pending <= 0;
		end else begin
			// Results are compared before this edge's input is added: no operation
			// finishes in the cycle in which it is taken.
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("result with nothing expected", read_value, '0);
				end else begin
					oldest = expected_results.pop_front();
					if (read_value !== oldest.read_value)
						flag_mismatch("read_value", read_value, oldest.read_value);
					if (length_now !== oldest.length_now)
						flag_mismatch("length_now", length_now, oldest.length_now);
					if (is_empty !== oldest.is_empty)
						flag_mismatch("is_empty", is_empty, oldest.is_empty);
					if (status !== oldest.status)
						flag_mismatch("status", status, oldest.status);
				end
				checked++;
			end
			if (in_valid && !in_stall) begin
				predict_list_op(op, position, item_value, new_length, next_expected);
				expected_results.push_back(next_expected);
			end
			pending <= expected_results.size();
		end
	end

endmodule

/* tb/sv/tb_indexed_list_insert_remove_top.sv */
`timescale 1ns / 100ps
// Testbench top for the indexed list: drives operation beats and result back-pressure, and gives
// the verdict. Depends on ilir_pkg, indexed_list_insert_remove_top and ilir_result_checker.
module tb_indexed_list_insert_remove_top
	import ilir_pkg::*;
();

	localparam int         DEPTH        = 64;
	localparam int         VALUE_BITS   = 32;
	localparam logic [2:0] OP_UNUSED    = 3'd7;
	localparam int         RANDOM_ITEMS = 900;
	localparam int         TREND_SPAN   = 80;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         DRAIN_CYCLES = 300;

	typedef enum {GAPS_NONE, GAPS_ALWAYS, GAPS_SOME} gap_style_t;
	typedef enum {TREND_GROW, TREND_SHRINK, TREND_LEVEL} trend_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [2:0]                op;
	logic [POS_W-1:0]          position;
	logic signed [VALUE_W-1:0] item_value;
	logic [POS_W-1:0]          new_length;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [VALUE_W-1:0] read_value;
	logic [POS_W-1:0]          length_now;
	logic                      is_empty;
	logic [STS_W-1:0]          status;

	int mismatches;
	int pending;
	int checked;

	// What the stimulus knows of the list, so that it can aim at valid indexes and
	// never read a slot that holds nothing written.
	int         list_len;
	bit         slot_written [DEPTH];
	gap_style_t send_style;
	trend_t     trend;
	int         op_tally [8];
	int         refused_total;
	int         deepest;

	indexed_list_insert_remove_top #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.position   (position),
		.item_value (item_value),
		.new_length (new_length),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.length_now (length_now),
		.is_empty   (is_empty),
		.status     (status)
	);

	ilir_result_checker #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.position   (position),
		.item_value (item_value),
		.new_length (new_length),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.length_now (length_now),
		.is_empty   (is_empty),
		.status     (status),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap(gap_style_t style);
		case (style)
		GAPS_NONE:   return 0;
		GAPS_ALWAYS: return $urandom_range(0, 19);
		default:     return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
		endcase
	endfunction

	// Tracks the list as the operation will change it, then hands the beat over.
	task automatic send_op(input logic [2:0] code, input logic [POS_W-1:0] pos,
			input logic [VALUE_W-1:0] val, input logic [POS_W-1:0] req);
		logic [2:0] code_used;
		logic       refused;
		int         gap;
		code_used = code;
		// A slot exposed by a length grow holds nothing defined, so it is written
		// rather than read.
		if (code_used == OP_READ && pos < list_len && !slot_written[pos])
			code_used = OP_WRITE;
		refused = 1'b0;
		case (code_used)
		OP_APPEND: begin
			if (list_len >= DEPTH) begin
				refused = 1'b1;
			end else begin
				slot_written[list_len] = 1'b1;
				list_len++;
			end
		end
		OP_INSERT: begin
			if (pos > list_len || list_len >= DEPTH) begin
				refused = 1'b1;
			end else begin
				for (int i = list_len; i > pos; i--)
					slot_written[i] = slot_written[i - 1];
				slot_written[pos] = 1'b1;
				list_len++;
			end
		end
		OP_REMOVE: begin
			if (pos >= list_len) begin
				refused = 1'b1;
			end else begin
				for (int i = pos; i + 1 < list_len; i++)
					slot_written[i] = slot_written[i + 1];
				list_len--;
			end
		end
		OP_READ: begin
			refused = (pos >= list_len);
		end
		OP_WRITE: begin
			if (pos >= list_len)
				refused = 1'b1;
			else
				slot_written[pos] = 1'b1;
		end
		OP_CLEAR: begin
			list_len = 0;
		end
		OP_SETLEN: begin
			if (req > DEPTH)
				refused = 1'b1;
			else
				list_len = req;
		end
		default: begin
		end
		endcase
		op_tally[code_used]++;
		refused_total += refused;
		if (list_len > deepest)
			deepest = list_len;

		gap = draw_gap(send_style);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code_used;
		position <= pos;
		item_value <= val;
		new_length <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Mostly well-formed operations at valid indexes, with some noise at any index.
	task automatic send_random_op();
		int               r;
		int               grow_weight;
		int               tries;
		logic [2:0]       code;
		logic [POS_W-1:0] pos;
		logic [VALUE_W-1:0] val;
		logic [POS_W-1:0] req;
		grow_weight = (trend == TREND_GROW) ? 45 : (trend == TREND_SHRINK) ? 10 : 28;
		r = $urandom_range(0, 99);
		if (r < grow_weight)
			code = ($urandom_range(0, 1) != 0) ? OP_APPEND : OP_INSERT;
		else if (r < 55)
			code = OP_REMOVE;
		else if (r < 75)
			code = OP_READ;
		else if (r < 89)
			code = OP_WRITE;
		else if (r < 96)
			code = OP_SETLEN;
		else if (r < 97)
			code = OP_CLEAR;
		else
			code = OP_UNUSED;

		if ($urandom_range(0, 99) < 15) begin
			pos = POS_W'($urandom_range(0, DEPTH));
		end else if (code == OP_INSERT) begin
			pos = POS_W'($urandom_range(0, list_len));
		end else if (list_len > 0) begin
			pos = POS_W'($urandom_range(0, list_len - 1));
			for (tries = 0; code == OP_READ && !slot_written[pos] && tries < 8; tries++)
				pos = POS_W'($urandom_range(0, list_len - 1));
		end else begin
			pos = POS_W'($urandom_range(0, DEPTH));
		end

		case ($urandom_range(0, 15))
		0:       val = 32'h7FFF_FFFF;
		1:       val = 32'h8000_0000;
		2:       val = '0;
		3:       val = '1;
		default: val = $urandom;
		endcase

		r = $urandom_range(0, 19);
		if (r == 0)
			req = POS_W'($urandom_range(DEPTH + 1, (1 << POS_W) - 1));
		else if (r < 3)
			req = POS_W'(DEPTH);
		else
			req = POS_W'($urandom_range(0, DEPTH));

		send_op(code, pos, val, req);
	endtask

	// Result side: a random stall, possibly none, before each result beat.
	initial begin
		int         hold;
		gap_style_t stall_style;
		out_stall <= 1'b0;
		stall_style = GAPS_SOME;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				stall_style = gap_style_t'($urandom_range(0, 2));
			hold = draw_gap(stall_style);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		in_valid <= 1'b0;
		op <= OP_APPEND;
		position <= '0;
		item_value <= '0;
		new_length <= '0;
		arst_n <= 1'b0;
		list_len = 0;
		refused_total = 0;
		deepest = 0;
		send_style = GAPS_SOME;
		trend = TREND_LEVEL;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Operations on the empty list all fail on the index.
		send_op(OP_READ, 7'd0, '0, '0);
		send_op(OP_REMOVE, 7'd0, '0, '0);
		send_op(OP_WRITE, 7'd0, 32'h1234_5678, '0);
		send_op(OP_INSERT, 7'd1, 32'h0BAD_F00D, '0);
		// Build four entries with the value extremes, inserting at the front, the end
		// and the middle.
		send_op(OP_INSERT, 7'd0, 32'h7FFF_FFFF, '0);
		send_op(OP_APPEND, 7'd0, 32'h8000_0000, '0);
		send_op(OP_INSERT, 7'd2, 32'hFFFF_FFFF, '0);
		send_op(OP_INSERT, 7'd1, 32'h0000_0000, '0);
		for (int i = 0; i < 4; i++)
			send_op(OP_READ, POS_W'(i), '0, '0);
		send_op(OP_WRITE, 7'd3, 32'h5A5A_A5A5, '0);
		send_op(OP_READ, 7'd3, '0, '0);
		send_op(OP_REMOVE, 7'd3, '0, '0);
		send_op(OP_REMOVE, 7'd0, '0, '0);
		// Lengths beyond the store are refused; the full length is allowed.
		send_op(OP_SETLEN, '0, '0, '1);
		send_op(OP_SETLEN, '0, '0, 7'd65);
		send_op(OP_SETLEN, '0, '0, 7'd64);
		send_op(OP_APPEND, '0, 32'hCAFE_0001, '0);
		send_op(OP_INSERT, 7'd64, 32'hCAFE_0002, '0);
		send_op(OP_INSERT, 7'd65, 32'hCAFE_0003, '0);
		send_op(OP_READ, '1, '0, '0);
		send_op(OP_REMOVE, 7'd63, '0, '0);
		send_op(OP_UNUSED, 7'd5, 32'hFFFF_0000, 7'd9);
		send_op(OP_CLEAR, '0, '0, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % TREND_SPAN == 0) begin
				trend = trend_t'($urandom_range(0, 2));
				send_style = gap_style_t'($urandom_range(0, 2));
			end
			send_random_op();
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d append, %0d insert, %0d remove, %0d read, %0d write, %0d clear,",
			op_tally[OP_APPEND], op_tally[OP_INSERT], op_tally[OP_REMOVE],
			op_tally[OP_READ], op_tally[OP_WRITE], op_tally[OP_CLEAR]);
		$display("%0d set length, %0d unused; %0d refused, deepest %0d, %0d checked, %0d bad.",
			op_tally[OP_SETLEN], op_tally[OP_UNUSED], refused_total, deepest, checked,
			mismatches);
		if (mismatches == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
